### rtl/hpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared types and constants of the HSV palette line generator.
// ----------------------------------------------------------------------------
package hpl_pkg;

	localparam int MAX_WIDTH       = 64;
	localparam int HUE_SECTOR_SIZE = 256;
	localparam int SECTOR_BITS     = $clog2(HUE_SECTOR_SIZE);
	localparam int NUM_SECTORS     = 6;
	localparam int VAL_FRAC_BITS   = 8;   // brightness is Q.8

	localparam int HUE_BITS   = 11;
	localparam int BRT_BITS   = 9;
	localparam int WIDTH_BITS = 7;
	localparam int IDX_BITS   = 6;
	localparam int TERM_BITS  = IDX_BITS + SECTOR_BITS;

	localparam logic [HUE_BITS-1:0]   HUE_PERIOD       = HUE_BITS'(NUM_SECTORS * HUE_SECTOR_SIZE);
	localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = 7'd16;

	// register index, taken from paddr[2]
	localparam logic REG_LINE_WIDTH = 1'b0;

	localparam logic [4:0] RB_MAX = 5'd31;
	localparam logic [5:0] G_MAX  = 6'd63;

	// ceil(2^20 / n): exact floor(q / n) for q below 2^13, n below 64
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

	typedef logic [RECIP_BITS-1:0] recip_t;

	localparam int RECIP_TABLE [64] = '{
		0,                  (RECIP_ONE+0)/1,    (RECIP_ONE+1)/2,    (RECIP_ONE+2)/3,
		(RECIP_ONE+3)/4,    (RECIP_ONE+4)/5,    (RECIP_ONE+5)/6,    (RECIP_ONE+6)/7,
		(RECIP_ONE+7)/8,    (RECIP_ONE+8)/9,    (RECIP_ONE+9)/10,   (RECIP_ONE+10)/11,
		(RECIP_ONE+11)/12,  (RECIP_ONE+12)/13,  (RECIP_ONE+13)/14,  (RECIP_ONE+14)/15,
		(RECIP_ONE+15)/16,  (RECIP_ONE+16)/17,  (RECIP_ONE+17)/18,  (RECIP_ONE+18)/19,
		(RECIP_ONE+19)/20,  (RECIP_ONE+20)/21,  (RECIP_ONE+21)/22,  (RECIP_ONE+22)/23,
		(RECIP_ONE+23)/24,  (RECIP_ONE+24)/25,  (RECIP_ONE+25)/26,  (RECIP_ONE+26)/27,
		(RECIP_ONE+27)/28,  (RECIP_ONE+28)/29,  (RECIP_ONE+29)/30,  (RECIP_ONE+30)/31,
		(RECIP_ONE+31)/32,  (RECIP_ONE+32)/33,  (RECIP_ONE+33)/34,  (RECIP_ONE+34)/35,
		(RECIP_ONE+35)/36,  (RECIP_ONE+36)/37,  (RECIP_ONE+37)/38,  (RECIP_ONE+38)/39,
		(RECIP_ONE+39)/40,  (RECIP_ONE+40)/41,  (RECIP_ONE+41)/42,  (RECIP_ONE+42)/43,
		(RECIP_ONE+43)/44,  (RECIP_ONE+44)/45,  (RECIP_ONE+45)/46,  (RECIP_ONE+46)/47,
		(RECIP_ONE+47)/48,  (RECIP_ONE+48)/49,  (RECIP_ONE+49)/50,  (RECIP_ONE+50)/51,
		(RECIP_ONE+51)/52,  (RECIP_ONE+52)/53,  (RECIP_ONE+53)/54,  (RECIP_ONE+54)/55,
		(RECIP_ONE+55)/56,  (RECIP_ONE+56)/57,  (RECIP_ONE+57)/58,  (RECIP_ONE+58)/59,
		(RECIP_ONE+59)/60,  (RECIP_ONE+60)/61,  (RECIP_ONE+61)/62,  (RECIP_ONE+62)/63
	};

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage
`default_nettype wire

### rtl/hpl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_if
// Stream channels of the palette line generator: hue/brightness in, pixels out.
// ----------------------------------------------------------------------------
interface hpl_in_if;
	logic        valid;
	logic        ready;
	logic [10:0] hue;
	logic [8:0]  brightness;

	modport source (output valid, hue, brightness, input ready);
	modport sink   (input valid, hue, brightness, output ready);
endinterface

interface hpl_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] red;
	logic [5:0] green;
	logic [4:0] blue;
	logic [5:0] pixel_index;
	logic       last;

	modport source (output valid, red, green, blue, pixel_index, last, input ready);
	modport sink   (input valid, red, green, blue, pixel_index, last, output ready);
endinterface
`default_nettype wire

### rtl/hsv_palette_line_rgb565.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_palette_line_rgb565
// HSV palette line generator: one hue/brightness item in, line_width RGB565
// pixels out, chroma ramping from zero to full across the line.
// ----------------------------------------------------------------------------
// Usage:
//   hsv_in  : valid/ready item of hue (1/256 sector units) and brightness (Q.8).
//   pix_out : valid/ready pixel items, red/green/blue, pixel_index, last.
//   APB     : register 0 (byte 0) is line_width, 7 bits, 0 acts as 1,
//             above 64 acts as 64. Write it only while the block is idle.
// Timing:
//   A line sequencer issues one pixel per cycle, while the output is not
//   stalled, into a four-stage pipeline (pixel issue, channel terms,
//   channel products, reciprocal divide and saturate into the output reg).
//   The next item is taken in the cycle the last pixel of the current
//   line issues.
// Reset:
//   line_width returns to 16, sequencer and pipeline are emptied.
// Stall:
//   when pix_out.ready is low with a pixel waiting, every stage holds and
//   the sequencer issues no pixel; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_palette_line_rgb565
	import hpl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	hpl_in_if.sink           hsv_in,
	hpl_out_if.source        pix_out
);

	// ---------------- configuration ----------------
	logic [WIDTH_BITS-1:0] line_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_LINE_WIDTH) begin
			line_width_q <= pwdata[WIDTH_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LINE_WIDTH) ? {25'd0, line_width_q} : 32'd0;

	// effective width, last index and divisor n
	logic [WIDTH_BITS-1:0] width_c;
	logic [IDX_BITS-1:0]   last_idx;
	logic [IDX_BITS-1:0]   n_c;
	logic                  single;

	always_comb begin
		if (line_width_q == '0) begin
			width_c = 7'd1;
		end else if (line_width_q > WIDTH_BITS'(MAX_WIDTH)) begin
			width_c = WIDTH_BITS'(MAX_WIDTH);
		end else begin
			width_c = line_width_q;
		end
		last_idx = IDX_BITS'(width_c - 7'd1);
		single   = (width_c == 7'd1);
		// a one-pixel line acts as the last pixel of a two-pixel line
		n_c      = single ? 6'd1 : last_idx;
	end

	// ---------------- input decode ----------------
	logic [HUE_BITS-1:0]    hue_w;
	logic [SECTOR_BITS-1:0] frac_in;
	logic [SECTOR_BITS:0]   fnum_in;
	sector_t                sector_in;

	always_comb begin
		hue_w     = (hsv_in.hue >= HUE_PERIOD) ? hsv_in.hue - HUE_PERIOD : hsv_in.hue;
		sector_in = sector_t'(hue_w[HUE_BITS-1:SECTOR_BITS]);
		frac_in   = hue_w[SECTOR_BITS-1:0];
		// falling sectors count down from a full sector
		fnum_in   = hue_w[SECTOR_BITS] ? (SECTOR_BITS+1)'(HUE_SECTOR_SIZE) - {1'b0, frac_in}
		                               : {1'b0, frac_in};
	end

	// ---------------- line sequencer ----------------
	logic                busy_q;
	logic [IDX_BITS-1:0] cnt_q;
	sector_t             sector_q;
	logic [SECTOR_BITS:0] fnum_q;
	logic [BRT_BITS-1:0] bright_q;

	logic en, issue, end_line, accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign en           = !vld_s4 || pix_out.ready;
	assign issue        = busy_q && en;
	assign end_line     = (cnt_q == last_idx);
	assign hsv_in.ready = !busy_q || (issue && end_line);
	assign accept       = hsv_in.valid && hsv_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (issue) begin
			if (end_line) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sector_q <= sector_in;
			fnum_q   <= fnum_in;
			bright_q <= hsv_in.brightness;
		end
	end

	// ---------------- pipeline valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// ---------------- stage 1: pixel issue ----------------
	sector_t              sector_s1;
	logic [SECTOR_BITS:0] fnum_s1;
	logic [BRT_BITS-1:0]  bright_s1;
	logic [IDX_BITS-1:0]  k_s1, nk_s1, n_s1, idx_s1;
	logic                 last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= sector_q;
			fnum_s1   <= fnum_q;
			bright_s1 <= bright_q;
			k_s1      <= single ? 6'd1 : cnt_q;
			nk_s1     <= single ? 6'd0 : last_idx - cnt_q;
			n_s1      <= n_c;
			idx_s1    <= cnt_q;
			last_s1   <= end_line;
		end
	end

	// ---------------- stage 2: channel terms ----------------
	// channel = floor(V*scale*T / (n * 2^8 * sector_size)), T per channel:
	// full n*s, rising/falling k*fnum + (n-k)*s, floor (n-k)*s
	logic [TERM_BITS-1:0] kf, tx, tz, tf, tr, tg, tb;
	logic [13:0]          v31;
	logic [14:0]          v63;

	always_comb begin
		kf  = TERM_BITS'(k_s1) * TERM_BITS'(fnum_s1);
		tz  = {nk_s1, {SECTOR_BITS{1'b0}}};
		tf  = {n_s1, {SECTOR_BITS{1'b0}}};
		tx  = kf + tz;
		v31 = {bright_s1, 5'd0} - 14'(bright_s1);
		v63 = {bright_s1, 6'd0} - 15'(bright_s1);
		case (sector_s1)
			SEC_RED_YEL: begin tr = tf; tg = tx; tb = tz; end
			SEC_YEL_GRN: begin tr = tx; tg = tf; tb = tz; end
			SEC_GRN_CYN: begin tr = tz; tg = tf; tb = tx; end
			SEC_CYN_BLU: begin tr = tz; tg = tx; tb = tf; end
			SEC_BLU_MAG: begin tr = tx; tg = tz; tb = tf; end
			SEC_MAG_RED: begin tr = tf; tg = tz; tb = tx; end
			default:     begin tr = tf; tg = tz; tb = tx; end
		endcase
	end

	logic [TERM_BITS-1:0] tr_s2, tg_s2, tb_s2;
	logic [13:0]          v31_s2;
	logic [14:0]          v63_s2;
	recip_t               recip_s2;
	logic [IDX_BITS-1:0]  idx_s2;
	logic                 last_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s2    <= tr;
			tg_s2    <= tg;
			tb_s2    <= tb;
			v31_s2   <= v31;
			v63_s2   <= v63;
			recip_s2 <= RECIP_BITS'(RECIP_TABLE[n_s1]);
			idx_s2   <= idx_s1;
			last_s2  <= last_s1;
		end
	end

	// ---------------- stage 3: channel products ----------------
	localparam int QSH = VAL_FRAC_BITS + SECTOR_BITS;

	logic [27:0] ar, ab;
	logic [28:0] ag;

	always_comb begin
		ar = 28'(v31_s2) * 28'(tr_s2);
		ag = 29'(v63_s2) * 29'(tg_s2);
		ab = 28'(v31_s2) * 28'(tb_s2);
	end

	logic [27-QSH:0] qr_s3, qb_s3;
	logic [28-QSH:0] qg_s3;
	recip_t          recip_s3;
	logic [IDX_BITS-1:0] idx_s3;
	logic            last_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s3    <= ar[27:QSH];
			qg_s3    <= ag[28:QSH];
			qb_s3    <= ab[27:QSH];
			recip_s3 <= recip_s2;
			idx_s3   <= idx_s2;
			last_s3  <= last_s2;
		end
	end

	// ---------------- stage 4: divide by n, saturate ----------------
	logic [32:0] pr, pb;
	logic [33:0] pg;
	logic [12:0] quo_r, quo_b;
	logic [13:0] quo_g;

	always_comb begin
		pr    = 33'(qr_s3) * 33'(recip_s3);
		pg    = 34'(qg_s3) * 34'(recip_s3);
		pb    = 33'(qb_s3) * 33'(recip_s3);
		quo_r = pr[32:RECIP_SHIFT];
		quo_g = pg[33:RECIP_SHIFT];
		quo_b = pb[32:RECIP_SHIFT];
	end

	logic [4:0]          red_s4, blue_s4;
	logic [5:0]          green_s4;
	logic [IDX_BITS-1:0] idx_s4;
	logic                last_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			red_s4   <= (quo_r > 13'(RB_MAX)) ? RB_MAX : quo_r[4:0];
			green_s4 <= (quo_g > 14'(G_MAX))  ? G_MAX  : quo_g[5:0];
			blue_s4  <= (quo_b > 13'(RB_MAX)) ? RB_MAX : quo_b[4:0];
			idx_s4   <= idx_s3;
			last_s4  <= last_s3;
		end
	end

	assign pix_out.valid       = vld_s4;
	assign pix_out.red         = red_s4;
	assign pix_out.green       = green_s4;
	assign pix_out.blue        = blue_s4;
	assign pix_out.pixel_index = idx_s4;
	assign pix_out.last        = last_s4;

	// ---------------- assertions ----------------
	a_accept_starts_line: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && cnt_q == '0)
		else $error("accepted item did not start a line at pixel zero");

	a_stall_holds_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !en) |=> busy_q && $stable(cnt_q))
		else $error("sequencer advanced during output stall");

	a_mid_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && !end_line) |=> busy_q && cnt_q == $past(cnt_q) + 6'd1)
		else $error("line ended before its last pixel");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !en) |=> vld_s3 && $stable(qg_s3) && $stable(idx_s3))
		else $error("pipeline stage changed during stall");

endmodule
`default_nettype wire
